### rtl/segment_triangle_intersect_macros.svh
// Assertion macros for the segment/triangle intersection block.
`ifndef SEGMENT_TRIANGLE_INTERSECT_MACROS_SVH
`define SEGMENT_TRIANGLE_INTERSECT_MACROS_SVH
`ifndef NO_ASSERTIONS
// checked only while out of reset
`define STI_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("sti assertion failed");
// checked during reset as well
`define STI_ASSERT_RST(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("sti reset assertion failed");
`else
`define STI_ASSERT(label, prop)
`define STI_ASSERT_RST(label, prop)
`endif
`endif

### rtl/sti_pkg.sv
// Shared constants for the segment/triangle intersection block.
package sti_pkg;

    // multiplier digit width, one digit per pipeline stage
    localparam int DIGIT_W = 16;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SEG_START_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEG_START_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEG_START_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEG_END_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SEG_END_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SEG_END_Z   = 3'd5;

endpackage

### rtl/segment_triangle_intersect.sv
// Top level: segment against triangle intersection pipeline.
// One triangle per clock is accepted while the pipeline is not held, and one result per
// triangle comes out, in order. The latency is set by the crossing-point divider, which
// resolves one quotient bit per stage, plus the digit-serial multiplier stages for the plane
// distances, the crossing interpolation and the edge tests. The whole pipeline advances
// together and holds when a finished result is not taken. Segment registers are to be
// written through the config port only while no transaction is in flight; the block does
// not enforce this. Indexes beyond the segment end z register are ignored.
`include "segment_triangle_intersect_macros.svh"
module segment_triangle_intersect #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sti_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]              i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [COORD_WIDTH-1:0]       i_vertex_a_x,
    input  logic signed [COORD_WIDTH-1:0]       i_vertex_a_y,
    input  logic signed [COORD_WIDTH-1:0]       i_vertex_a_z,
    input  logic signed [COORD_WIDTH-1:0]       i_vertex_b_x,
    input  logic signed [COORD_WIDTH-1:0]       i_vertex_b_y,
    input  logic signed [COORD_WIDTH-1:0]       i_vertex_b_z,
    input  logic signed [COORD_WIDTH-1:0]       i_vertex_c_x,
    input  logic signed [COORD_WIDTH-1:0]       i_vertex_c_y,
    input  logic signed [COORD_WIDTH-1:0]       i_vertex_c_z,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_plane_crossed,
    output logic                                o_hit,
    output logic signed [COORD_WIDTH-1:0]       o_cross_x,
    output logic signed [COORD_WIDTH-1:0]       o_cross_y,
    output logic signed [COORD_WIDTH-1:0]       o_cross_z
);

    localparam int W    = COORD_WIDTH;
    localparam int D    = W + 1;
    localparam int N    = 2 * W + 3;
    localparam int DW   = 3 * W + 6;
    localparam int PDW  = N + D;
    localparam int MW   = DW + W;
    localparam int NMW  = MW + 1;
    localparam int NW   = 4 * W + 11;
    localparam int DVW  = DW + 2;
    localparam int EW   = 2 * N + 2;
    localparam int DG   = sti_pkg::DIGIT_W;
    localparam int LD   = (D + DG - 1) / DG;
    localparam int LE   = (W + DG - 1) / DG;
    localparam int LN   = (N + DG - 1) / DG;
    localparam int DLY_V = 6 + LD + LE + W;
    localparam int LAT  = 10 + LD + LE + W + LN;

    function automatic logic [D-1:0] dif(input logic [W-1:0] x, input logic [W-1:0] y);
        dif = D'($signed(x)) - D'($signed(y));
    endfunction

    function automatic logic [2*D-1:0] pmul(input logic [D-1:0] x, input logic [D-1:0] y);
        logic signed [2*D-1:0] r;
        r = $signed(x) * $signed(y);
        pmul = r;
    endfunction

    function automatic logic [N-1:0] ndif(input logic [2*D-1:0] x, input logic [2*D-1:0] y);
        ndif = N'($signed(x)) - N'($signed(y));
    endfunction

    // config
    logic [2:0][W-1:0] r_seg_s;
    logic [2:0][W-1:0] r_seg_e;

    // control
    logic           en;
    logic [LAT-1:0] r_vld;

    // stage 1
    logic [8:0][W-1:0] in_v;
    logic [2:0][D-1:0] s1_e01, s1_e02, s1_ds, s1_de;
    logic [8:0][D-1:0] s1_ed;
    logic [8:0][W-1:0] r1_v;
    logic [2:0][D-1:0] r1_e01, r1_e02, r1_ds, r1_de;
    logic [8:0][D-1:0] r1_ed;

    // stages 2..5
    logic [5:0][2*D-1:0] s2_np, r2_np;
    logic [2:0][D-1:0]   r2_ds, r2_de, r3_ds, r3_de;
    logic [2:0][N-1:0]   s3_n, r3_n;
    logic [2:0][PDW-1:0] pd0, pd1;
    logic [DW-1:0]       s5_d0, s5_d1, r5_d0, r5_d1;

    // stages 6..8
    logic [DW:0]         s5_den, dl7_den;
    logic                s5_cr, s5_dz, dl7_cr, dl7_dz;
    logic [2:0][MW-1:0]  me0, me1;
    logic [2:0][NMW-1:0] s7_num, r7_num;
    logic [2:0][NW-1:0]  s8_x, r8_x;
    logic [DVW-1:0]      s8_d2, r8_d2;
    logic                r8_cr, r8_dz;

    // stages 9..10
    logic [2:0][W-1:0]   dq;
    logic                dl9_cr, dl9_dz;
    logic [2:0][W-1:0]   s10_p, r10_p;
    logic                r10_cr;
    logic [8:0][W-1:0]   dl_v;
    logic [8:0][D-1:0]   dl_ed;

    // stages 11..14
    logic [8:0][D-1:0]    s11_t2;
    logic [17:0][2*D-1:0] s11_cp, r11_cp;
    logic                 r11_cr, r12_cr;
    logic [2:0][W-1:0]    r11_p, r12_p;
    logic [8:0][N-1:0]    s12_c, r12_c;
    logic [2:0][N-1:0]    dl_n;
    logic [8:0][2*N-1:0]  pe;
    logic                 dl13_cr;
    logic [2:0][W-1:0]    dl13_p;
    logic [EW-1:0]        s14_sum [3];
    logic                 s14_hit;
    logic                 r_out_cr, r_out_hit;
    logic [2:0][W-1:0]    r_out_p;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_s <= '0;
            r_seg_e <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sti_pkg::REG_SEG_START_X: r_seg_s[0] <= i_cfg_data;
                sti_pkg::REG_SEG_START_Y: r_seg_s[1] <= i_cfg_data;
                sti_pkg::REG_SEG_START_Z: r_seg_s[2] <= i_cfg_data;
                sti_pkg::REG_SEG_END_X:   r_seg_e[0] <= i_cfg_data;
                sti_pkg::REG_SEG_END_Y:   r_seg_e[1] <= i_cfg_data;
                sti_pkg::REG_SEG_END_Z:   r_seg_e[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // global advance: move unless the output register is full and not taken
    assign en          = !r_vld[LAT-1] || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    assign in_v = {i_vertex_c_z, i_vertex_c_y, i_vertex_c_x,
                   i_vertex_b_z, i_vertex_b_y, i_vertex_b_x,
                   i_vertex_a_z, i_vertex_a_y, i_vertex_a_x};

    // edge vectors and endpoint offsets
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s1_e01[i] = dif(in_v[3+i], in_v[i]);
            s1_e02[i] = dif(in_v[6+i], in_v[i]);
            s1_ds[i]  = dif(r_seg_s[i], in_v[i]);
            s1_de[i]  = dif(r_seg_e[i], in_v[i]);
        end
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
                s1_ed[k*3+i] = dif(in_v[((k == 2) ? 0 : k + 1)*3+i], in_v[k*3+i]);
            end
        end
    end

    // face normal cross products
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s2_np[2*i]   = pmul(r1_e01[(i + 1) % 3], r1_e02[(i + 2) % 3]);
            s2_np[2*i+1] = pmul(r1_e01[(i + 2) % 3], r1_e02[(i + 1) % 3]);
            s3_n[i]      = ndif(r2_np[2*i], r2_np[2*i+1]);
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_dot
        sti_mul #(.WA(N), .WB(D)) u_mul_d0 (
            .i_clk (i_clk), .i_en (en),
            .i_a   (r3_n[i]), .i_b (r3_ds[i]), .o_p (pd0[i])
        );
        sti_mul #(.WA(N), .WB(D)) u_mul_d1 (
            .i_clk (i_clk), .i_en (en),
            .i_a   (r3_n[i]), .i_b (r3_de[i]), .o_p (pd1[i])
        );
    end

    assign s5_d0 = DW'($signed(pd0[0])) + DW'($signed(pd0[1])) + DW'($signed(pd0[2]));
    assign s5_d1 = DW'($signed(pd1[0])) + DW'($signed(pd1[1])) + DW'($signed(pd1[2]));

    // plane test
    assign s5_den = (DW + 1)'($signed(r5_d0)) - (DW + 1)'($signed(r5_d1));
    assign s5_cr  = (r5_d0 == '0) || (r5_d1 == '0) || (r5_d0[DW-1] != r5_d1[DW-1]);
    assign s5_dz  = (s5_den == '0);

    sti_dly #(.WIDTH(DW + 3), .DEPTH(LE + 1)) u_dly_den (
        .i_clk (i_clk), .i_en (en),
        .i_d   ({s5_den, s5_cr, s5_dz}),
        .o_q   ({dl7_den, dl7_cr, dl7_dz})
    );

    for (genvar i = 0; i < 3; i++) begin : g_mule
        sti_mul #(.WA(DW), .WB(W)) u_mul_e (
            .i_clk (i_clk), .i_en (en),
            .i_a   (r5_d0), .i_b (r_seg_e[i]), .o_p (me0[i])
        );
        sti_mul #(.WA(DW), .WB(W)) u_mul_s (
            .i_clk (i_clk), .i_en (en),
            .i_a   (r5_d1), .i_b (r_seg_s[i]), .o_p (me1[i])
        );
        assign s7_num[i] = NMW'($signed(me0[i])) - NMW'($signed(me1[i]));
    end

    // round-half-up quotient, biased by half range so the division is unsigned
    always_comb begin
        logic signed [NW-1:0] den_a;
        logic signed [NW-1:0] num_a;
        logic signed [NW-1:0] n2;
        den_a = NW'($signed(dl7_den));
        if (dl7_den[DW]) begin
            den_a = -den_a;
        end
        s8_d2 = DVW'(den_a <<< 1);
        for (int i = 0; i < 3; i++) begin
            num_a = NW'($signed(r7_num[i]));
            if (dl7_den[DW]) begin
                num_a = -num_a;
            end
            n2      = (num_a <<< 1) + den_a;
            s8_x[i] = n2 + (NW'(s8_d2) << (W - 1));
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_div
        sti_div #(.XW(NW), .DVW(DVW), .QW(W)) u_div (
            .i_clk (i_clk), .i_en (en),
            .i_x   (r8_x[i]), .i_d (r8_d2), .o_q (dq[i])
        );
    end

    sti_dly #(.WIDTH(2), .DEPTH(W)) u_dly_flags (
        .i_clk (i_clk), .i_en (en),
        .i_d   ({r8_cr, r8_dz}),
        .o_q   ({dl9_cr, dl9_dz})
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (!dl9_cr) begin
                s10_p[i] = '0;
            end else if (dl9_dz) begin
                s10_p[i] = r_seg_s[i];
            end else begin
                s10_p[i] = {~dq[i][W-1], dq[i][W-2:0]};
            end
        end
    end

    sti_dly #(.WIDTH(9 * (W + D)), .DEPTH(DLY_V)) u_dly_vert (
        .i_clk (i_clk), .i_en (en),
        .i_d   ({r1_v, r1_ed}),
        .o_q   ({dl_v, dl_ed})
    );

    // edge tests: (v[k+1]-v[k]) x (p-v[k])
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
                s11_t2[k*3+i] = dif(r10_p[i], dl_v[k*3+i]);
            end
            for (int i = 0; i < 3; i++) begin
                s11_cp[k*6+2*i]   = pmul(dl_ed[k*3+(i + 1) % 3], s11_t2[k*3+(i + 2) % 3]);
                s11_cp[k*6+2*i+1] = pmul(dl_ed[k*3+(i + 2) % 3], s11_t2[k*3+(i + 1) % 3]);
                s12_c[k*3+i]      = ndif(r11_cp[k*6+2*i], r11_cp[k*6+2*i+1]);
            end
        end
    end

    sti_dly #(.WIDTH(3 * N), .DEPTH(DLY_V)) u_dly_n (
        .i_clk (i_clk), .i_en (en),
        .i_d   (r3_n),
        .o_q   (dl_n)
    );

    for (genvar j = 0; j < 9; j++) begin : g_edge
        sti_mul #(.WA(N), .WB(N)) u_mul_c (
            .i_clk (i_clk), .i_en (en),
            .i_a   (dl_n[j % 3]), .i_b (r12_c[j]), .o_p (pe[j])
        );
    end

    sti_dly #(.WIDTH(1 + 3 * W), .DEPTH(LN)) u_dly_out (
        .i_clk (i_clk), .i_en (en),
        .i_d   ({r12_cr, r12_p}),
        .o_q   ({dl13_cr, dl13_p})
    );

    always_comb begin
        s14_hit = dl13_cr;
        for (int k = 0; k < 3; k++) begin
            s14_sum[k] = EW'($signed(pe[k*3])) + EW'($signed(pe[k*3+1]))
                       + EW'($signed(pe[k*3+2]));
            if (s14_sum[k][EW-1]) begin
                s14_hit = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_v      <= in_v;
            r1_e01    <= s1_e01;
            r1_e02    <= s1_e02;
            r1_ds     <= s1_ds;
            r1_de     <= s1_de;
            r1_ed     <= s1_ed;
            r2_np     <= s2_np;
            r2_ds     <= r1_ds;
            r2_de     <= r1_de;
            r3_n      <= s3_n;
            r3_ds     <= r2_ds;
            r3_de     <= r2_de;
            r5_d0     <= s5_d0;
            r5_d1     <= s5_d1;
            r7_num    <= s7_num;
            r8_x      <= s8_x;
            r8_d2     <= s8_d2;
            r8_cr     <= dl7_cr;
            r8_dz     <= dl7_dz;
            r10_p     <= s10_p;
            r10_cr    <= dl9_cr;
            r11_cp    <= s11_cp;
            r11_cr    <= r10_cr;
            r11_p     <= r10_p;
            r12_c     <= s12_c;
            r12_cr    <= r11_cr;
            r12_p     <= r11_p;
            r_out_cr  <= dl13_cr;
            r_out_hit <= s14_hit;
            r_out_p   <= dl13_p;
        end
    end

    assign o_plane_crossed = r_out_cr;
    assign o_hit           = r_out_hit;
    assign o_cross_x       = r_out_p[0];
    assign o_cross_y       = r_out_p[1];
    assign o_cross_z       = r_out_p[2];

    `STI_ASSERT(a_hit_needs_cross, o_out_valid && o_hit |-> o_plane_crossed)
    `STI_ASSERT(a_miss_zero_point, o_out_valid && !o_plane_crossed |-> o_cross_x == '0 && o_cross_y == '0 && o_cross_z == '0)
    `STI_ASSERT_RST(a_reset_empty, !i_rst_n |=> !o_out_valid)

endmodule

### rtl/sti_dly.sv
// Enabled delay line for side data traveling alongside the pipeline.
module sti_dly #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_pipe [DEPTH];

    for (genvar k = 0; k < DEPTH; k++) begin : g_tap
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_pipe[k] <= i_d;
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_pipe[k] <= r_pipe[k-1];
                end
            end
        end
    end

    assign o_q = r_pipe[DEPTH-1];

endmodule

### rtl/sti_mul.sv
// Pipelined signed multiplier, one digit of the second operand per stage.
module sti_mul #(
    parameter int WA = 32,
    parameter int WB = 32
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [WA-1:0]    i_a,
    input  logic signed [WB-1:0]    i_b,
    output logic signed [WA+WB-1:0] o_p
);

    localparam int DG = sti_pkg::DIGIT_W;
    localparam int L  = (WB + DG - 1) / DG;
    localparam int BW = L * DG;
    localparam int PX = WA + BW + 1;

    logic signed [WA-1:0] r_a   [L];
    logic        [BW-1:0] r_b   [L];
    logic signed [PX-1:0] r_acc [L];
    logic        [BW-1:0] b_ext;

    assign b_ext = BW'(i_b);

    for (genvar k = 0; k < L; k++) begin : g_stage
        logic signed [WA-1:0]   a_in;
        logic        [BW-1:0]   b_in;
        logic signed [PX-1:0]   acc_in;
        logic signed [DG:0]     dig;
        logic signed [WA+DG:0]  part;

        if (k == 0) begin : g_first
            assign a_in   = i_a;
            assign b_in   = b_ext;
            assign acc_in = '0;
        end else begin : g_next
            assign a_in   = r_a[k-1];
            assign b_in   = r_b[k-1];
            assign acc_in = r_acc[k-1];
        end

        // top digit carries the sign
        if (k == L - 1) begin : g_sdig
            assign dig = $signed({b_in[BW-1], b_in[k*DG +: DG]});
        end else begin : g_udig
            assign dig = $signed({1'b0, b_in[k*DG +: DG]});
        end

        assign part = a_in * dig;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a[k]   <= a_in;
                r_b[k]   <= b_in;
                r_acc[k] <= acc_in + (PX'(part) <<< (k * DG));
            end
        end
    end

    assign o_p = r_acc[L-1][WA+WB-1:0];

endmodule

### rtl/sti_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module sti_div #(
    parameter int XW  = 64,
    parameter int DVW = 32,
    parameter int QW  = 16
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [XW-1:0]  i_x,
    input  logic [DVW-1:0] i_d,
    output logic [QW-1:0]  o_q
);

    logic [XW-1:0]  r_rem [QW];
    logic [DVW-1:0] r_d   [QW];
    logic [QW-1:0]  r_q   [QW];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        localparam int SH = QW - 1 - j;
        logic [XW-1:0]  rem_in;
        logic [XW-1:0]  sub;
        logic [DVW-1:0] d_in;
        logic [QW-1:0]  q_in;
        logic           take;

        if (j == 0) begin : g_first
            assign rem_in = i_x;
            assign d_in   = i_d;
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = r_rem[j-1];
            assign d_in   = r_d[j-1];
            assign q_in   = r_q[j-1];
        end

        assign sub  = XW'(d_in) << SH;
        assign take = (rem_in >= sub);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= take ? (rem_in - sub) : rem_in;
                r_d[j]   <= d_in;
                r_q[j]   <= q_in | (QW'(take) << SH);
            end
        end
    end

    assign o_q = r_q[QW-1];

endmodule
